### design/phonetic_soundex_encoder_top_defines.svh
// Assertion macros shared by the phonetic code encoder RTL.
`ifndef PHONETIC_SOUNDEX_ENCODER_TOP_DEFINES_SVH
`define PHONETIC_SOUNDEX_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define PSENC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("psenc assertion failed");

// Check a property on every edge, reset included.
`define PSENC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("psenc assertion failed");

`else

`define PSENC_ASSERT(name, clk, rst, prop)
`define PSENC_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

### design/psenc_pkg.sv
// Types, constants and class codes of the phonetic code encoder.
`default_nettype none

package psenc_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int DIGIT_LIMIT = CODE_LENGTH - 1;
  localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
  localparam int NUM_SHOWN   = (DIGIT_LIMIT < 3) ? DIGIT_LIMIT : 3;

  localparam int CH_W    = 21;
  localparam int DIG_W   = 3;
  localparam int TALLY_W = 16;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CH_W-1:0] EMPTY_LEAD = CH_W'(48);

  // Character classes: 1..6 are consonant classes.
  localparam logic [3:0] CLS_NONE     = 4'd0;
  localparam logic [3:0] CLS_CONS_MIN = 4'd1;
  localparam logic [3:0] CLS_CONS_MAX = 4'd6;
  localparam logic [3:0] CLS_VOWEL    = 4'd7;
  localparam logic [3:0] CLS_SKIP     = 4'd8;
  localparam logic [3:0] CLS_UNKNOWN  = 4'd9;

  typedef logic [3:0] cls_t;

  typedef struct packed {
    cls_t            cls;
    logic [CH_W-1:0] lead;
    logic            is_empty;
    logic            last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic             at_start;
    logic [CNT_W-1:0] digits;
  } back_stat_t;

endpackage

`default_nettype wire

### design/psenc_front.sv
// Front end: take input beats, classify the character and queue the item.
`default_nettype none

module psenc_front (
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [psenc_pkg::IN_W-1:0] s_tdata,
  input  wire logic                       s_tuser,
  input  wire logic                       s_tlast,
  input  wire psenc_pkg::fifo_stat_t      fifo_stat,
  output logic                            push,
  output psenc_pkg::item_t                item
);

  logic [psenc_pkg::CH_W-1:0] ch;
  logic                       is_ascii;
  logic                       is_upper;
  logic                       is_lower;
  logic [7:0]                 lc;
  psenc_pkg::cls_t            cls;

  assign ch       = s_tdata[psenc_pkg::CH_W-1:0];
  assign is_ascii = (ch[psenc_pkg::CH_W-1:7] == '0);
  assign is_upper = is_ascii && (ch[6:0] >= 7'h41) && (ch[6:0] <= 7'h5A);
  assign is_lower = is_ascii && (ch[6:0] >= 7'h61) && (ch[6:0] <= 7'h7A);
  assign lc       = {1'b0, ch[6], 1'b1, ch[4:0]};

  always_comb begin
    cls = psenc_pkg::CLS_UNKNOWN;
    if (is_upper || is_lower) begin
      unique case (lc)
        "a", "e", "i", "o", "u", "y":           cls = psenc_pkg::CLS_VOWEL;
        "b", "f", "p", "v":                     cls = 4'd1;
        "c", "g", "j", "k", "q", "s", "x", "z": cls = 4'd2;
        "d", "t":                               cls = 4'd3;
        "l":                                    cls = 4'd4;
        "m", "n":                               cls = 4'd5;
        "r":                                    cls = 4'd6;
        default:                                cls = psenc_pkg::CLS_SKIP;
      endcase
    end else if (is_ascii && (ch[6:0] >= 7'h20) && (ch[6:0] != 7'h7F)) begin
      cls = psenc_pkg::CLS_SKIP;
    end
  end

  assign s_tready = !fifo_stat.full;
  assign push     = s_tvalid && !fifo_stat.full;

  always_comb begin
    item.cls      = cls;
    item.lead     = is_lower ? (ch & ~psenc_pkg::CH_W'(32)) : ch;
    item.is_empty = s_tuser;
    item.last     = s_tlast;
  end

endmodule

`default_nettype wire

### design/psenc_fifo.sv
// Short queue of classified items between front and back ends.
`default_nettype none

module psenc_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire psenc_pkg::item_t      item_in,
  input  wire logic                  pop,
  output psenc_pkg::item_t           item_out,
  output psenc_pkg::fifo_stat_t      stat
);

  psenc_pkg::item_t                  mem [psenc_pkg::FIFO_DEPTH];
  logic [psenc_pkg::FIFO_PW-1:0]     wr_ptr;
  logic [psenc_pkg::FIFO_PW-1:0]     rd_ptr;
  logic [psenc_pkg::FIFO_CW-1:0]     count;

  assign stat.full  = (count == psenc_pkg::FIFO_CW'(psenc_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign item_out   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + psenc_pkg::FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + psenc_pkg::FIFO_PW'(1);
      end
      if (push && !pop) begin
        count <= count + psenc_pkg::FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - psenc_pkg::FIFO_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/psenc_back.sv
// Back end: merge classes, collect digits, hold the result beat.
`default_nettype none

module psenc_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire psenc_pkg::item_t            item,
  input  wire psenc_pkg::fifo_stat_t       fifo_stat,
  output logic                             pop,
  output psenc_pkg::back_stat_t            stat,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [psenc_pkg::OUT_W-1:0]      m_tdata
);

  logic [2:0]                          prev_class;
  logic [2:0]                          prev_class_next;
  logic [psenc_pkg::CNT_W-1:0]         digits;
  logic [psenc_pkg::CNT_W-1:0]         digits_next;
  logic [psenc_pkg::CH_W-1:0]          lead;
  logic [psenc_pkg::CH_W-1:0]          lead_next;
  logic [psenc_pkg::TALLY_W-1:0]       tally;
  logic [psenc_pkg::TALLY_W-1:0]       tally_next;
  logic                                at_start;
  logic                                at_start_next;
  logic [psenc_pkg::DIG_W-1:0]         store      [psenc_pkg::DIGIT_LIMIT];
  logic [psenc_pkg::DIG_W-1:0]         store_next [psenc_pkg::DIGIT_LIMIT];
  logic [psenc_pkg::DIG_W-1:0]         dig_out    [3];
  logic                                is_cons;
  logic                                wr;
  logic                                ends;
  logic                                out_free;
  logic [psenc_pkg::OUT_W-1:0]         result;

  assign is_cons  = (item.cls >= psenc_pkg::CLS_CONS_MIN) &&
                    (item.cls <= psenc_pkg::CLS_CONS_MAX);
  assign ends     = item.is_empty || item.last;
  assign out_free = !m_tvalid || m_tready;
  assign pop      = !fifo_stat.empty && (!ends || out_free);

  assign stat.at_start = at_start;
  assign stat.digits   = digits;

  always_comb begin
    prev_class_next = prev_class;
    digits_next     = digits;
    lead_next       = lead;
    tally_next      = tally;
    at_start_next   = at_start;
    wr              = 1'b0;
    if (at_start) begin
      lead_next       = item.lead;
      tally_next      = (item.cls == psenc_pkg::CLS_UNKNOWN) ? psenc_pkg::TALLY_W'(1) : '0;
      prev_class_next = is_cons ? item.cls[2:0] : '0;
      digits_next     = '0;
      at_start_next   = 1'b0;
    end else if (digits < psenc_pkg::CNT_W'(psenc_pkg::DIGIT_LIMIT)) begin
      if (item.cls == psenc_pkg::CLS_VOWEL) begin
        prev_class_next = '0;
      end else if (is_cons) begin
        if (item.cls[2:0] != prev_class) begin
          wr              = 1'b1;
          digits_next     = digits + psenc_pkg::CNT_W'(1);
          prev_class_next = item.cls[2:0];
        end
      end else if (item.cls == psenc_pkg::CLS_UNKNOWN) begin
        if (tally != '1) begin
          tally_next = tally + psenc_pkg::TALLY_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < psenc_pkg::DIGIT_LIMIT; k++) begin
      store_next[k] = (wr && (digits == psenc_pkg::CNT_W'(k))) ? item.cls[2:0] : store[k];
    end
    for (int k = 0; k < 3; k++) begin
      dig_out[k] = '0;
    end
    // Digits not yet found read as padding.
    for (int k = 0; k < psenc_pkg::NUM_SHOWN; k++) begin
      if (digits_next > psenc_pkg::CNT_W'(k)) begin
        dig_out[k] = store_next[k];
      end
    end
  end

  always_comb begin
    if (item.is_empty) begin
      result = {2'b00, psenc_pkg::TALLY_W'(0), 3'd0, 3'd0, 3'd0, psenc_pkg::EMPTY_LEAD};
    end else begin
      result = {2'b00, tally_next, dig_out[2], dig_out[1], dig_out[0], lead_next};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      store <= store_next;
      lead  <= lead_next;
    end
    if (pop && ends) begin
      m_tdata <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= '0;
      digits     <= '0;
      tally      <= '0;
      at_start   <= 1'b1;
      m_tvalid   <= 1'b0;
    end else begin
      if (pop) begin
        if (ends) begin
          prev_class <= '0;
          digits     <= '0;
          tally      <= '0;
          at_start   <= 1'b1;
        end else begin
          prev_class <= prev_class_next;
          digits     <= digits_next;
          tally      <= tally_next;
          at_start   <= at_start_next;
        end
      end
      if (pop && ends) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/phonetic_soundex_encoder_top.sv
// A string-ending beat is queued, then registered onto m_tdata when it is popped from the queue.
// Throughput: one input beat per cycle while the queue has space, limited by the single pop per cycle of the queue.
// A result beat waiting in the output register does not stop non-ending beats.
// Reset (rst, synchronous, active high) empties the queue, drops any pending result
// and puts the encoder at the start of a string.
`default_nettype none

`include "phonetic_soundex_encoder_top_defines.svh"

module phonetic_soundex_encoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input stream: one character per beat.
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [psenc_pkg::IN_W-1:0]  s_tdata,  // [20:0] ch, [23:21] zero
  input  wire logic                        s_tuser,  // [0] is_empty
  input  wire logic                        s_tlast,  // last character of the string
  // Output stream: one phonetic code per ended string.
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [psenc_pkg::OUT_W-1:0]      m_tdata   // [20:0] lead_char, [23:21] digit_one,
                                                     // [26:24] digit_two, [29:27] digit_three,
                                                     // [45:30] fail_count, [47:46] zero
);

  psenc_pkg::fifo_stat_t fifo_stat;
  psenc_pkg::back_stat_t back_stat;
  psenc_pkg::item_t      push_item;
  psenc_pkg::item_t      head_item;
  logic                  push;
  logic                  pop;
  logic                  head_ends;
  logic                  idle;

  // Classify the character and queue it; ready only tracks queue space.
  psenc_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .item      (push_item)
  );

  // Decouple classification from the merge so either side can stall alone.
  psenc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (push_item),
    .pop      (pop),
    .item_out (head_item),
    .stat     (fifo_stat)
  );

  // Merge classes, count unknowns and hold the result beat for the sink.
  psenc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (head_item),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .stat      (back_stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  assign head_ends = head_item.is_empty || head_item.last;
  assign idle      = !m_tvalid && fifo_stat.empty && back_stat.at_start;

  // Reset leaves no result, an empty queue and the string start.
  `PSENC_ASSERT_ALWAYS(a_reset_clean, clk, rst |=> idle)

  // The digit count never passes the digit limit, one less than the code length.
  `PSENC_ASSERT(a_digit_bound, clk, rst, back_stat.digits <= psenc_pkg::CNT_W'(psenc_pkg::DIGIT_LIMIT))

  // An ending item leaves the queue only when the output register can take it.
  `PSENC_ASSERT(a_no_overwrite, clk, rst, (pop && head_ends) |-> (!m_tvalid || m_tready))

  // Nothing is popped from an empty queue.
  `PSENC_ASSERT(a_no_underflow, clk, rst, pop |-> !fifo_stat.empty)

endmodule

`default_nettype wire
